[src/ptst_pkg.sv]
// Package for the periodic timer slot table: command codes and the sequencer state type.
// No dependencies; imported by periodic_timer_slot_table_unit.
`default_nettype none

package ptst_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REMOVE,
    ST_POLL,
    ST_FINISH,
    ST_BAD
  } state_t;

endpackage

`default_nettype wire

[src/periodic_timer_slot_table_unit.sv]
// Periodic timer slot table: slot memories, active bits and the scanning sequencer.
// Depends on ptst_pkg for command codes and the state type.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+-----------------------------------
//   command  | start in, busy out        | cmd, now, period, slot
//   result   | strobe out (one cycle)    | ok, slot_out, fired, last
//
// A transaction is accepted on a rising edge with start high and busy low.
// Add walks the active bits from slot 0 until it meets a free slot or reaches
// the last one. Poll streams the slots through the period and last-tick
// memories, one slot a cycle with the read data registered, and a closing
// step sends the final result; the single 32-bit subtract and compare decides
// whether a slot is due. Remove and unused command codes answer without a scan.
// Every result appears on the registered outputs in the cycle after the sequencer
// produces it, and the block takes the next transaction as soon as busy is low.
// Synchronous reset clears the active bits and the sequencer; the memories are
// not cleared, since an entry is only read once an add has written it.
// The receiver cannot stall: each result is held for exactly one cycle.
`default_nettype none

module periodic_timer_slot_table_unit
  import ptst_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] now,
  input  wire logic [31:0] period,
  input  wire logic [5:0]  slot,
  output logic             strobe,
  output logic             ok,
  output logic [5:0]       slot_out,
  output logic             fired,
  output logic             last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Sequencer state.
  state_t state, state_next;

  // Captured transaction fields.
  logic [31:0] now_r;
  logic [31:0] period_r;
  logic [5:0]  slot_r;

  // Slot storage: active bits in flip-flops, period and last tick in memories.
  logic [SLOTS-1:0] active, active_next;
  logic [31:0]      mem_period [SLOTS];
  logic [31:0]      mem_tick   [SLOTS];
  logic [31:0]      rd_period;
  logic [31:0]      rd_tick;

  // Scan counter and the compare stage behind the memory read.
  logic [IW-1:0] idx, idx_next;
  logic          scan_on, scan_on_next;
  logic          chk_valid, chk_valid_next;
  logic [IW-1:0] chk_idx, chk_idx_next;

  // A due slot is held back until the next one is found, so that the final
  // result of a poll can carry the last flag.
  logic          pend_valid, pend_valid_next;
  logic [IW-1:0] pend_slot, pend_slot_next;

  // Memory write controls.
  logic          period_we;
  logic          tick_we;
  logic [IW-1:0] wr_addr;

  // Result register inputs.
  logic       strobe_next;
  logic       ok_next;
  logic [5:0] slot_out_next;
  logic       fired_next;
  logic       last_next;

  logic        accept;
  logic        slot_in_range;
  logic [31:0] elapsed;
  logic        due;

  assign accept        = start && (state == ST_IDLE);
  assign busy          = (state != ST_IDLE);
  assign slot_in_range = ({1'b0, slot_r} < 7'(SLOTS));

  // The shared compare unit: wrapping elapsed time against the period.
  assign elapsed = now_r - rd_tick;
  assign due     = chk_valid && active[chk_idx] && (elapsed >= rd_period);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_ADD:    state_next = ST_ADD;
            CMD_REMOVE: state_next = ST_REMOVE;
            CMD_POLL:   state_next = ST_POLL;
            default:    state_next = ST_BAD;
          endcase
        end
      end
      ST_ADD: begin
        if (!active[idx] || (idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      ST_POLL: begin
        if (chk_valid && (chk_idx == LAST_IDX)) begin
          state_next = ST_FINISH;
        end
      end
      ST_REMOVE: state_next = ST_IDLE;
      ST_FINISH: state_next = ST_IDLE;
      ST_BAD:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath and result logic.
  always_comb begin
    idx_next        = idx;
    scan_on_next    = scan_on;
    chk_valid_next  = 1'b0;
    chk_idx_next    = idx;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    active_next     = active;
    period_we       = 1'b0;
    tick_we         = 1'b0;
    wr_addr         = idx;
    strobe_next     = 1'b0;
    ok_next         = 1'b0;
    slot_out_next   = 6'd0;
    fired_next      = 1'b0;
    last_next       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          idx_next        = '0;
          scan_on_next    = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      ST_ADD: begin
        if (!active[idx]) begin
          active_next[idx] = 1'b1;
          period_we        = 1'b1;
          tick_we          = 1'b1;
          strobe_next      = 1'b1;
          ok_next          = 1'b1;
          slot_out_next    = 6'(idx);
          last_next        = 1'b1;
        end else if (idx == LAST_IDX) begin
          // Table full.
          strobe_next = 1'b1;
          last_next   = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_REMOVE: begin
        if (slot_in_range) begin
          active_next[slot_r[IW-1:0]] = 1'b0;
        end
        strobe_next = 1'b1;
        ok_next     = slot_in_range;
        last_next   = 1'b1;
      end
      ST_POLL: begin
        chk_valid_next = scan_on;
        chk_idx_next   = idx;
        if (scan_on) begin
          if (idx == LAST_IDX) begin
            scan_on_next = 1'b0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        if (due) begin
          tick_we         = 1'b1;
          wr_addr         = chk_idx;
          pend_valid_next = 1'b1;
          pend_slot_next  = chk_idx;
          if (pend_valid) begin
            strobe_next   = 1'b1;
            ok_next       = 1'b1;
            slot_out_next = 6'(pend_slot);
            fired_next    = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        // Either the held-back due slot or the single nothing-due result.
        strobe_next   = 1'b1;
        ok_next       = 1'b1;
        slot_out_next = pend_valid ? 6'(pend_slot) : 6'd0;
        fired_next    = pend_valid;
        last_next     = 1'b1;
      end
      ST_BAD: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      scan_on    <= 1'b0;
      chk_valid  <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      active     <= active_next;
      scan_on    <= scan_on_next;
      chk_valid  <= chk_valid_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r    <= now;
      period_r <= period;
      slot_r   <= slot;
    end
    idx       <= idx_next;
    chk_idx   <= chk_idx_next;
    pend_slot <= pend_slot_next;
    ok        <= ok_next;
    slot_out  <= slot_out_next;
    fired     <= fired_next;
    last      <= last_next;
  end

  // Slot memories: one write port each, one registered read at the scan index.
  always_ff @(posedge clk) begin
    if (period_we) begin
      mem_period[wr_addr] <= period_r;
    end
    if (tick_we) begin
      mem_tick[wr_addr] <= now_r;
    end
    rd_period <= mem_period[idx];
    rd_tick   <= mem_tick[idx];
  end

  // A fired result always reports success.
  assert property (@(posedge clk) disable iff (rst) strobe && fired |-> ok)
    else $error("fired result without ok");

  // Only a poll produces more than one result, so any non-final result fired.
  assert property (@(posedge clk) disable iff (rst) strobe && !last |-> fired)
    else $error("non-final result that did not fire");

  // The closing step of a poll always delivers the final result.
  assert property (@(posedge clk) disable iff (rst) state == ST_FINISH |=> strobe && last)
    else $error("poll ended without a final result");

  // The sequencer only leaves idle on an accepted transaction.
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy without an accepted transaction");

  // A scan compare is never pending once the block is idle again.
  assert property (@(posedge clk) disable iff (rst) state == ST_IDLE |-> !chk_valid)
    else $error("compare stage active while idle");

endmodule

`default_nettype wire

[sim/periodic_timer_slot_table_unit_tb.sv]
// Self-checking testbench for periodic_timer_slot_table_unit: a directed table, then
// random traffic. Depends on ptst_pkg for the command codes and on the unit itself.
`timescale 1ns / 100ps

module periodic_timer_slot_table_unit_tb
  import ptst_pkg::*;
();

  localparam int SLOT_COUNT      = 8;
  localparam int DIRECTED_ROWS   = 25;
  localparam int RANDOM_ITEMS    = 405;
  localparam int WATCHDOG_CYCLES = 2000;
  // The package names only the three real commands; code 3 is the unused one.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One command transaction as driven on the input ports.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] period;
    logic [5:0]  slot;
  } timer_req_t;

  // One result as it appears on the output ports during a strobe.
  typedef struct packed {
    logic       ok;
    logic [5:0] slot;
    logic       fired;
    logic       last;
  } timer_reply_t;

  // A row of the directed script. Where typed is set, the reply is written out by
  // hand and replaces the prediction for that row.
  typedef struct packed {
    timer_req_t   req;
    logic         typed;
    timer_reply_t reply;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = CMD_ADD;
  logic [31:0] now = '0;
  logic [31:0] period = '0;
  logic [5:0]  slot = '0;
  logic        strobe;
  logic        ok;
  logic [5:0]  slot_out;
  logic        fired;
  logic        last;

  // Our own copy of the timer table, updated as each transaction is accepted.
  logic [SLOT_COUNT-1:0] tbl_active;
  logic [31:0]           tbl_period [SLOT_COUNT];
  logic [31:0]           tbl_stamp  [SLOT_COUNT];

  timer_reply_t awaited_replies [$];
  timer_reply_t fresh_replies [$];
  script_row_t  script [DIRECTED_ROWS];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;

  periodic_timer_slot_table_unit #(
    .SLOTS(SLOT_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .now(now),
    .period(period),
    .slot(slot),
    .strobe(strobe),
    .ok(ok),
    .slot_out(slot_out),
    .fired(fired),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the replies that one accepted transaction causes and applies its
  // effect on the table. An add takes the lowest free slot; a remove beyond the
  // table is refused and changes nothing; a poll fires every active slot whose
  // wrapping age has reached its period, in ascending order, and answers with a
  // single quiet reply when nothing is due. The unused code gets a bare reply.
  function automatic void advance_timer_table(timer_req_t req);
    timer_reply_t rep;
    logic [31:0]  age;
    fresh_replies.delete();
    rep = '{ok: 1'b0, slot: 6'd0, fired: 1'b0, last: 1'b1};
    case (req.op)
      CMD_ADD: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!tbl_active[i] && !rep.ok) begin
            tbl_active[i] = 1'b1;
            tbl_period[i] = req.period;
            tbl_stamp[i]  = req.now;
            rep.ok   = 1'b1;
            rep.slot = 6'(i);
          end
        end
        fresh_replies.push_back(rep);
      end
      CMD_REMOVE: begin
        if (int'(req.slot) < SLOT_COUNT) begin
          tbl_active[req.slot] = 1'b0;
          rep.ok = 1'b1;
        end
        fresh_replies.push_back(rep);
      end
      CMD_POLL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          age = req.now - tbl_stamp[i];
          if (tbl_active[i] && age >= tbl_period[i]) begin
            tbl_stamp[i] = req.now;
            fresh_replies.push_back('{ok: 1'b1, slot: 6'(i), fired: 1'b1, last: 1'b0});
          end
        end
        if (fresh_replies.size() == 0) begin
          rep.ok = 1'b1;
          fresh_replies.push_back(rep);
        end else begin
          rep = fresh_replies.pop_back();
          rep.last = 1'b1;
          fresh_replies.push_back(rep);
        end
      end
      default: begin
        fresh_replies.push_back(rep);
      end
    endcase
  endfunction

  // Idle time before the next transaction: mostly none or a few cycles, now and
  // then a long pause, and occasional runs with no idling at all.
  function automatic int unsigned next_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic script_row_t row(logic [1:0] op, logic [31:0] t, logic [31:0] p,
                                      logic [5:0] s, logic typed = 1'b0, logic want_ok = 1'b0,
                                      logic [5:0] want_slot = 6'd0, logic want_fired = 1'b0);
    row = '{req: '{op, t, p, s}, typed: typed,
            reply: '{ok: want_ok, slot: want_slot, fired: want_fired, last: 1'b1}};
  endfunction

  // Presents one transaction after the given idle time and holds it until the
  // block takes it. Inputs move only on the falling edge, and busy is looked at
  // on the rising edge, so every signal gets a single assignment per time step.
  task automatic issue(timer_req_t req, int unsigned gap, logic typed, timer_reply_t typed_reply);
    for (int g = 0; g < gap; g++) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start  <= 1'b1;
    cmd    <= req.op;
    now    <= req.now;
    period <= req.period;
    slot   <= req.slot;
    do @(posedge clk); while (busy);
    advance_timer_table(req);
    if (typed) begin
      awaited_replies.push_back(typed_reply);
    end else begin
      foreach (fresh_replies[i]) awaited_replies.push_back(fresh_replies[i]);
    end
  endtask

  // Holds the sender off until every reply still owed has been seen.
  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker. The receiver cannot stall, so every strobe is a transaction
  // and is matched against the oldest reply still owed.
  always @(posedge clk) begin : result_check
    timer_reply_t want;
    if (!rst && strobe) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok=%0d slot=%0d fired=%0d",
                 $time, ok, slot_out, fired);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        compare_field("ok", 32'(want.ok), 32'(ok));
        compare_field("slot_out", 32'(want.slot), 32'(slot_out));
        compare_field("fired", 32'(want.fired), 32'(fired));
        compare_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Watchdog: any accepted command or result counts as progress. The longest
  // quiet stretch of a correct run is a long sender pause plus one full poll.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    timer_req_t  req;
    int unsigned pick;
    logic [31:0] clock_now;

    tbl_active = '0;
    foreach (tbl_period[i]) begin
      tbl_period[i] = '0;
      tbl_stamp[i]  = '0;
    end
    clock_now = 32'd1000;

    // Directed script. It starts on the empty table, walks the refusals and the
    // unused code, fills every slot including the extreme periods, tries an add
    // on a full table, then polls across the wrap of the tick counter and around
    // the sign boundary after freeing and reclaiming slots.
    script = '{
      row(CMD_POLL,   32'h0000_0000, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 6'd0, 1'b0),
      row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 6'd63, 1'b1, 1'b0),
      row(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd8,  1'b1, 1'b0),
      row(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000, 6'd7,  1'b1, 1'b1),
      row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0),
      row(CMD_ADD,    32'hFFFF_FFFF, 32'h0000_0000, 6'd63, 1'b1, 1'b1, 6'd0),
      row(CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 6'd1),
      row(CMD_ADD,    32'd100,       32'd10,        6'd0),
      row(CMD_ADD,    32'd100,       32'd20,        6'd5),
      row(CMD_ADD,    32'd100,       32'd30,        6'd0),
      row(CMD_ADD,    32'd100,       32'd40,        6'd0),
      row(CMD_ADD,    32'd100,       32'h5555_5555, 6'd0),
      row(CMD_ADD,    32'd100,       32'hAAAA_AAAA, 6'd0),
      row(CMD_ADD,    32'd200,       32'd1,         6'd0,  1'b1, 1'b0, 6'd0),
      row(CMD_POLL,   32'd110,       32'd0,         6'd0),
      row(CMD_POLL,   32'hFFFF_FFFF, 32'd0,         6'd0),
      row(CMD_POLL,   32'h0000_0005, 32'd0,         6'd0),
      row(CMD_REMOVE, 32'd0,         32'd0,         6'd0,  1'b1, 1'b1),
      row(CMD_ADD,    32'd5,         32'd1,         6'd0,  1'b1, 1'b1, 6'd0),
      row(CMD_POLL,   32'd6,         32'd0,         6'd0),
      row(CMD_REMOVE, 32'd0,         32'd0,         6'd3,  1'b1, 1'b1),
      row(CMD_REMOVE, 32'd0,         32'd0,         6'd5,  1'b1, 1'b1),
      row(CMD_ADD,    32'd7,         32'd2,         6'd0,  1'b1, 1'b1, 6'd3),
      row(CMD_POLL,   32'h7FFF_FFFF, 32'd0,         6'd0),
      row(CMD_POLL,   32'h8000_0000, 32'd0,         6'd0)
    };

    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) issue(script[i].req, next_gap(), script[i].typed, script[i].reply);
    drain_replies();

    // Random traffic. Adds carry the running tick so timers behave as in use,
    // with short periods mostly so that polls fire often; removes mostly name a
    // slot inside the table; polls advance the tick in small steps with the odd
    // jump anywhere in the 32-bit range. The ignored fields carry random values.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick       = $urandom_range(0, 99);
      req.now    = $urandom;
      req.period = $urandom;
      req.slot   = 6'($urandom);
      if (pick < 3) begin
        req.op = CMD_UNUSED;
      end else if (pick < 33) begin
        req.op = CMD_ADD;
        if ($urandom_range(0, 9) != 0) req.now = clock_now;
        case ($urandom_range(0, 9))
          0: req.period = '0;
          1: req.period = $urandom;
          default: req.period = $urandom_range(1, 60);
        endcase
      end else if (pick < 55) begin
        req.op = CMD_REMOVE;
        if ($urandom_range(0, 6) != 0) req.slot = 6'($urandom_range(0, SLOT_COUNT - 1));
      end else begin
        req.op = CMD_POLL;
        if ($urandom_range(0, 19) == 0) begin
          clock_now = $urandom;
        end else begin
          clock_now = clock_now + $urandom_range(0, 40);
        end
        req.now = clock_now;
      end
      issue(req, next_gap(), 1'b0, '0);
      if (n % 100 == 99) drain_replies();
    end

    // Wind down: wait for every reply, then keep watching in case anything stray
    // follows, and report any reply still owed.
    drain_replies();
    repeat (SLOT_COUNT + 4) @(posedge clk);
    if (awaited_replies.size() != 0) begin
      $display("%0t: missing results, expected %0d more, actual 0",
               $time, awaited_replies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
